FILE: rtl/core/bmsc_pkg.sv
// Package for the binary shape canonical form pipeline.
// Holds the shape type, dimension constants and the mirror, transpose and key functions.
// Depends on nothing.
package bmsc_pkg;

    localparam int Side    = 10;
    localparam int DimW    = 4;
    localparam int KeyW    = Side * Side;
    localparam int FieldsW = 2 * DimW + KeyW;
    localparam int TdataW  = ((FieldsW + 7) / 8) * 8;
    localparam int NumImg  = 8;

    typedef logic [Side-1:0] t_row;

    typedef struct packed {
        logic [DimW-1:0]       w;
        logic [DimW-1:0]       h;
        t_row [Side-1:0]       rows;
    } t_shape;

    function automatic logic [DimW-1:0] f_clamp(input logic [DimW-1:0] v);
        logic [DimW-1:0] r;
        if (v == '0) begin
            r = DimW'(1);
        end else if (v > DimW'(Side)) begin
            r = DimW'(Side);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_shape f_transpose(input t_shape s);
        t_shape d;
        d.w = s.h;
        d.h = s.w;
        for (int i = 0; i < Side; i++) begin
            for (int c = 0; c < Side; c++) begin
                d.rows[i][c] = s.rows[c][i];
            end
        end
        return d;
    endfunction

    function automatic t_shape f_flip_rows(input t_shape s);
        t_shape          d;
        logic [DimW-1:0] idx;
        d = s;
        for (int i = 0; i < Side; i++) begin
            idx = s.h - DimW'(1) - DimW'(i);
            if (DimW'(i) < s.h) begin
                d.rows[i] = s.rows[idx];
            end else begin
                d.rows[i] = '0;
            end
        end
        return d;
    endfunction

    function automatic t_shape f_flip_cols(input t_shape s);
        t_shape          d;
        t_row            rev;
        logic [DimW-1:0] sh;
        d  = s;
        sh = DimW'(Side) - s.w;
        for (int i = 0; i < Side; i++) begin
            for (int c = 0; c < Side; c++) begin
                rev[Side-1-c] = s.rows[i][c];
            end
            d.rows[i] = rev >> sh;
        end
        return d;
    endfunction

    // Row 0 lands in the most significant bits so that one unsigned compare
    // gives the row-by-row order.
    function automatic logic [KeyW-1:0] f_key(input t_shape s);
        logic [KeyW-1:0] k;
        for (int i = 0; i < Side; i++) begin
            k[KeyW-1-i*Side -: Side] = s.rows[i];
        end
        return k;
    endfunction

endpackage

FILE: rtl/core/bmsc_norm.sv
// First pipeline stage: clamps the dimensions, clears stray cells and
// builds the wide base and, if square, its transpose; uses bmsc_pkg.
module bmsc_norm
    import bmsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_shape i_shape,
    output logic   o_valid,
    input  logic   i_ready,
    output t_shape o_base,
    output t_shape o_trans
);

    logic   r_valid;
    t_shape r_base;
    t_shape r_trans;
    t_shape n_base;
    t_shape n_trans;
    t_shape s;
    t_shape t;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        s.w = f_clamp(i_shape.w);
        s.h = f_clamp(i_shape.h);
        for (int i = 0; i < Side; i++) begin
            for (int c = 0; c < Side; c++) begin
                s.rows[i][c] = i_shape.rows[i][c] && (DimW'(c) < s.w) && (DimW'(i) < s.h);
            end
        end
        t = f_transpose(s);
        priority if (s.w == s.h) begin
            n_base  = s;
            n_trans = t;
        end else if (s.w < s.h) begin
            n_base  = t;
            n_trans = t;
        end else begin
            n_base  = s;
            n_trans = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_base  <= n_base;
            r_trans <= n_trans;
        end
    end

    assign o_valid = r_valid;
    assign o_base  = r_base;
    assign o_trans = r_trans;

endmodule

FILE: rtl/core/bmsc_flip.sv
// Second pipeline stage: forms the four mirror images of the base shape and
// of its transpose. Depends on bmsc_pkg.
module bmsc_flip
    import bmsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_shape               i_base,
    input  t_shape               i_trans,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_shape [NumImg-1:0]  o_images
);

    logic                r_valid;
    t_shape [NumImg-1:0] r_images;
    t_shape [NumImg-1:0] n_images;
    t_shape              base_v;
    t_shape              trans_v;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        base_v      = f_flip_rows(i_base);
        trans_v     = f_flip_rows(i_trans);
        n_images[0] = i_base;
        n_images[1] = base_v;
        n_images[2] = f_flip_cols(base_v);
        n_images[3] = f_flip_cols(i_base);
        n_images[4] = i_trans;
        n_images[5] = trans_v;
        n_images[6] = f_flip_cols(trans_v);
        n_images[7] = f_flip_cols(i_trans);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_images <= n_images;
        end
    end

    assign o_valid  = r_valid;
    assign o_images = r_images;

endmodule

FILE: rtl/core/bmsc_min.sv
// Registered level of the minimum tree: keeps the lesser shape of each pair.
// Depends on bmsc_pkg.
module bmsc_min
    import bmsc_pkg::*;
#(
    parameter int NumIn = NumImg
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_shape [NumIn-1:0]    i_shapes,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_shape [NumIn/2-1:0]  o_shapes
);

    localparam int NumOut = NumIn / 2;

    logic                r_valid;
    t_shape [NumOut-1:0] r_shapes;
    t_shape [NumOut-1:0] n_shapes;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        for (int k = 0; k < NumOut; k++) begin
            if (f_key(i_shapes[2*k+1]) < f_key(i_shapes[2*k])) begin
                n_shapes[k] = i_shapes[2*k+1];
            end else begin
                n_shapes[k] = i_shapes[2*k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_shapes <= n_shapes;
        end
    end

    assign o_valid  = r_valid;
    assign o_shapes = r_shapes;

endmodule

FILE: rtl/core/bit_matrix_symmetry_canonical_form.sv
// Top level of the binary shape canonical form block.
// Chains bmsc_norm, bmsc_flip and three bmsc_min levels; depends on bmsc_pkg.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         112    shape_width, shape_height, row_0 .. row_9
//  m_axis    out        112    canon_width, canon_height, canon_row_0 .. canon_row_9
//
// A shape passes through five register stages (normalize, mirror, and three levels of
// the minimum tree) that each hold one shape, and a new shape is accepted in every cycle
// while no stage is stalled.
// Every stage is ready when it is empty or its successor is ready, so a stall
// fills empty stages first and drops nothing. Reset clears the valid bits only.
module bit_matrix_symmetry_canonical_form
    import bmsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // shape_width[3:0], shape_height[7:4], row_0 .. row_9 (10 bits each), zero fill
    input  logic [TdataW-1:0] i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // canon_width[3:0], canon_height[7:4], canon_row_0 .. canon_row_9, zero fill
    output logic [TdataW-1:0] o_m_tdata
);

    localparam int Lvl1 = NumImg;
    localparam int Lvl2 = NumImg / 2;
    localparam int Lvl3 = NumImg / 4;

    t_shape              in_shape;
    t_shape              base;
    t_shape              trans;
    t_shape [Lvl1-1:0]   images;
    t_shape [Lvl2-1:0]   min_a;
    t_shape [Lvl3-1:0]   min_b;
    t_shape [0:0]        result;
    logic                norm_valid;
    logic                norm_ready;
    logic                flip_valid;
    logic                flip_ready;
    logic                ma_valid;
    logic                ma_ready;
    logic                mb_valid;
    logic                mb_ready;

    always_comb begin
        in_shape.w = i_s_tdata[DimW-1:0];
        in_shape.h = i_s_tdata[2*DimW-1:DimW];
        for (int i = 0; i < Side; i++) begin
            in_shape.rows[i] = i_s_tdata[2*DimW+i*Side +: Side];
        end
    end

    bmsc_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_shape (in_shape),
        .o_valid (norm_valid),
        .i_ready (norm_ready),
        .o_base  (base),
        .o_trans (trans)
    );

    bmsc_flip u_flip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (norm_valid),
        .o_ready  (norm_ready),
        .i_base   (base),
        .i_trans  (trans),
        .o_valid  (flip_valid),
        .i_ready  (flip_ready),
        .o_images (images)
    );

    bmsc_min #(.NumIn(Lvl1)) u_min_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (flip_valid),
        .o_ready  (flip_ready),
        .i_shapes (images),
        .o_valid  (ma_valid),
        .i_ready  (ma_ready),
        .o_shapes (min_a)
    );

    bmsc_min #(.NumIn(Lvl2)) u_min_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ma_valid),
        .o_ready  (ma_ready),
        .i_shapes (min_a),
        .o_valid  (mb_valid),
        .i_ready  (mb_ready),
        .o_shapes (min_b)
    );

    bmsc_min #(.NumIn(Lvl3)) u_min_c (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (mb_valid),
        .o_ready  (mb_ready),
        .i_shapes (min_b),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_shapes (result)
    );

    always_comb begin
        o_m_tdata                    = '0;
        o_m_tdata[DimW-1:0]          = result[0].w;
        o_m_tdata[2*DimW-1:DimW]     = result[0].h;
        for (int i = 0; i < Side; i++) begin
            o_m_tdata[2*DimW+i*Side +: Side] = result[0].rows[i];
        end
    end

`ifndef SYNTHESIS
    a_wide_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (result[0].w >= result[0].h))
        else $error("canonical shape is taller than wide");

    a_dims_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (result[0].h != '0 && result[0].h <= DimW'(Side)
                        && result[0].w != '0 && result[0].w <= DimW'(Side)))
        else $error("canonical dimensions out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled while output register is empty");
`endif

endmodule
